// ===== hdl/fmvc_pkg.sv =====
// Shared types, codes and constants of the FM voice capture and dedupe block.
package fmvc_pkg;

  // Register address of the key-on write
  localparam logic [7:0] KEYON_ADDR = 8'h08;

  // Upper three address bits of each per-channel register group
  localparam logic [2:0] GRP_CONNECT = 3'd1;  // 0x20 + ch
  localparam logic [2:0] GRP_DT1MUL  = 3'd2;  // 0x40 + 8*op + ch
  localparam logic [2:0] GRP_TL      = 3'd3;  // 0x60 + 8*op + ch
  localparam logic [2:0] GRP_KSAR    = 3'd4;  // 0x80 + 8*op + ch
  localparam logic [2:0] GRP_AMED1R  = 3'd5;  // 0xa0 + 8*op + ch
  localparam logic [2:0] GRP_DT2D2R  = 3'd6;  // 0xc0 + 8*op + ch
  localparam logic [2:0] GRP_D1LRR   = 3'd7;  // 0xe0 + 8*op + ch

  // Read sweep over {group, operator}: from connect up to d1l_rr of operator 3
  localparam logic [4:0] SWEEP_FIRST = {GRP_CONNECT, 2'd0};
  localparam logic [4:0] SWEEP_LAST  = {GRP_D1LRR, 2'd3};

  // Field masks
  localparam logic [7:0] MASK_CONNECT = 8'h3f;
  localparam logic [7:0] MASK_KSAR    = 8'hdf;
  localparam logic [7:0] MASK_D1R     = 8'h9f;

  localparam logic [6:0] TL_MAX  = 7'd127;
  localparam int         NUM_OPS = 4;
  localparam logic [1:0] OP_LAST = 2'd3;

  // Carrier operators per connect algorithm, bit i marks operator i
  localparam logic [3:0] CARRIER_SETS [8] = '{
    4'h8, 4'h8, 4'h8, 4'h8, 4'hc, 4'he, 4'he, 4'hf
  };

  // One operator's parameter bytes, already masked
  typedef struct packed {
    logic [6:0] dt1_mul;
    logic [6:0] tl;
    logic [7:0] ks_ar;
    logic [7:0] ame_d1r;
    logic [7:0] dt2_d2r;
    logic [7:0] d1l_rr;
  } op_params_t;

  // One stored voice
  typedef struct packed {
    logic [5:0]                    connect;
    op_params_t [NUM_OPS-1:0]      ops;
  } voice_t;

  // Shadow register file write request
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } shadow_wr_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_MIN,
    ST_SUB,
    ST_SEARCH,
    ST_RESULT
  } state_t;

endpackage

// ===== hdl/fmvc_in_if.sv =====
// Request channel carrying one FM register write per request.
interface fmvc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;

  modport source (output valid, output reg_addr, output reg_data, input ready);
  modport sink   (input valid, input reg_addr, input reg_data, output ready);
endinterface

// ===== hdl/fmvc_out_if.sv =====
// Result channel carrying one voice lookup outcome per request.
interface fmvc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] voice_index;
  logic       is_new;
  logic       table_full;
  logic [2:0] key_channel;

  modport source (output valid, output voice_index, output is_new, output table_full,
                  output key_channel, input ready);
  modport sink   (input valid, input voice_index, input is_new, input table_full,
                  input key_channel, output ready);
endinterface

// ===== hdl/fmvc_shadow_regs.sv =====
// Shadow register file: 256 bytes, one write and one registered read per cycle.
module fmvc_shadow_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  fmvc_pkg::shadow_wr_t wr,
  input  logic [7:0]         rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0]   mem [256];
  logic [255:0] vld_r;
  logic [7:0]   rd_data_r;
  logic         rd_vld_r;

  // Mark written entries; reset makes every entry read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_data_r : 8'h00;

endmodule

// ===== hdl/fmvc_voice_table.sv =====
// Voice table memory: one write and one registered read per cycle.
module fmvc_voice_table #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  fmvc_pkg::voice_t wr_data,
  input  logic [IW-1:0]    rd_addr,
  output fmvc_pkg::voice_t rd_data
);

  fmvc_pkg::voice_t mem [DEPTH];
  fmvc_pkg::voice_t rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/fm_voice_capture_dedupe_unit.sv =====
// Top level of the FM voice capture and dedupe block.
//
// in_ch takes one FM register write per request (reg_addr, reg_data). Any
// address other than key-on goes into the shadow register file and gives no
// result; the block is ready again in the next cycle. A key-on write with
// zero slot bits is dropped without a result.
// A key-on with slot bits set snapshots the named channel's voice and gives
// one result on out_ch: the table index of the matching or newly appended
// voice, is_new, table_full and the key channel.
// A key-on goes through an acceptance step, the shadow file reads (one read
// port), 8 steps of the shared 7-bit subtractor for the carrier level
// minimum and offset, then one voice table entry compared per cycle (one
// read port) up to the result register. in_ch.ready is low meanwhile.
// The result sits in an output register; when out_ch stalls, the block still
// takes the next request and stalls again only when a new key-on result is
// ready and the previous one has not been taken.
// Reset empties the voice table and makes the shadow file read as zero, all
// at once; the block is ready in the first cycle after reset.
module fm_voice_capture_dedupe_unit #(
  parameter int MAX_VOICES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  fmvc_in_if.sink      in_ch,
  fmvc_out_if.source   out_ch
);

  localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_VOICES);

  fmvc_pkg::state_t state_r, state_nxt;

  logic [4:0]  idx_r, idx_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [2:0]  ch_r, ch_nxt;
  logic [5:0]  connect_r, connect_nxt;
  fmvc_pkg::op_params_t [fmvc_pkg::NUM_OPS-1:0] snap_r, snap_nxt;

  logic        rd_pend_r, rd_pend_nxt;
  logic [2:0]  rd_grp_r, rd_grp_nxt;
  logic [1:0]  rd_op_r, rd_op_nxt;

  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;

  logic [5:0]  res_index_r, res_index_nxt;
  logic        res_new_r, res_new_nxt;
  logic        res_full_r, res_full_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  out_index_r, out_index_nxt;
  logic        out_new_r, out_new_nxt;
  logic        out_full_r, out_full_nxt;
  logic [2:0]  out_ch_r, out_ch_nxt;

  fmvc_pkg::shadow_wr_t sh_wr;
  logic [7:0]  sh_rd_addr;
  logic [7:0]  sh_rd_data;

  logic             tbl_wr_en;
  logic [IW-1:0]    tbl_rd_addr;
  fmvc_pkg::voice_t tbl_rd_data;
  fmvc_pkg::voice_t snap_voice;

  logic [3:0]  carriers;
  logic [6:0]  alu_a;
  logic [7:0]  alu_diff;
  logic        alu_borrow;

  fmvc_shadow_regs u_shadow (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (sh_wr),
    .rd_addr (sh_rd_addr),
    .rd_data (sh_rd_data)
  );

  fmvc_voice_table #(
    .DEPTH (MAX_VOICES),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (count_r[IW-1:0]),
    .wr_data (snap_voice),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  assign snap_voice.connect = connect_r;
  assign snap_voice.ops     = snap_r;

  // Shared subtractor: carrier level against the running minimum
  assign carriers   = fmvc_pkg::CARRIER_SETS[connect_r[2:0]];
  assign alu_a      = snap_r[op_r].tl;
  assign alu_diff   = {1'b0, alu_a} - {1'b0, min_r};
  assign alu_borrow = alu_diff[7];

  assign sh_rd_addr = {idx_r, ch_r};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    min_nxt       = min_r;
    ch_nxt        = ch_r;
    connect_nxt   = connect_r;
    snap_nxt      = snap_r;
    rd_pend_nxt   = 1'b0;
    rd_grp_nxt    = rd_grp_r;
    rd_op_nxt     = rd_op_r;
    iss_nxt       = iss_r;
    count_nxt     = count_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    res_index_nxt = res_index_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_index_nxt = out_index_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    out_ch_nxt    = out_ch_r;
    sh_wr         = '0;
    tbl_wr_en     = 1'b0;
    tbl_rd_addr   = iss_r[IW-1:0];
    in_ch.ready   = 1'b0;

    // Capture the shadow byte read in the previous cycle into the snapshot
    if (rd_pend_r) begin
      case (rd_grp_r)
        fmvc_pkg::GRP_CONNECT: begin
          if (rd_op_r == 2'd0) begin
            connect_nxt = sh_rd_data[5:0] & fmvc_pkg::MASK_CONNECT[5:0];
          end
        end
        fmvc_pkg::GRP_DT1MUL: snap_nxt[rd_op_r].dt1_mul = sh_rd_data[6:0];
        fmvc_pkg::GRP_TL:     snap_nxt[rd_op_r].tl      = sh_rd_data[6:0];
        fmvc_pkg::GRP_KSAR:   snap_nxt[rd_op_r].ks_ar   = sh_rd_data & fmvc_pkg::MASK_KSAR;
        fmvc_pkg::GRP_AMED1R: snap_nxt[rd_op_r].ame_d1r = sh_rd_data & fmvc_pkg::MASK_D1R;
        fmvc_pkg::GRP_DT2D2R: snap_nxt[rd_op_r].dt2_d2r = sh_rd_data & fmvc_pkg::MASK_D1R;
        fmvc_pkg::GRP_D1LRR:  snap_nxt[rd_op_r].d1l_rr  = sh_rd_data;
        default: ;
      endcase
    end

    case (state_r)
      fmvc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.reg_addr != fmvc_pkg::KEYON_ADDR) begin
            sh_wr.en   = 1'b1;
            sh_wr.addr = in_ch.reg_addr;
            sh_wr.data = in_ch.reg_data;
          end else if (in_ch.reg_data[6:3] != 4'd0) begin
            ch_nxt    = in_ch.reg_data[2:0];
            idx_nxt   = fmvc_pkg::SWEEP_FIRST;
            state_nxt = fmvc_pkg::ST_GATHER;
          end
        end
      end

      // Sweep the channel's registers, one read per cycle
      fmvc_pkg::ST_GATHER: begin
        rd_pend_nxt = 1'b1;
        rd_grp_nxt  = idx_r[4:2];
        rd_op_nxt   = idx_r[1:0];
        idx_nxt     = idx_r + 5'd1;
        if (idx_r == fmvc_pkg::SWEEP_LAST) begin
          op_nxt    = 2'd0;
          min_nxt   = fmvc_pkg::TL_MAX;
          state_nxt = fmvc_pkg::ST_MIN;
        end
      end

      // Find the smallest carrier level
      fmvc_pkg::ST_MIN: begin
        if (carriers[op_r] && alu_borrow) begin
          min_nxt = alu_a;
        end
        op_nxt = op_r + 2'd1;
        if (op_r == fmvc_pkg::OP_LAST) begin
          state_nxt = fmvc_pkg::ST_SUB;
        end
      end

      // Offset every carrier level by that minimum
      fmvc_pkg::ST_SUB: begin
        if (carriers[op_r]) begin
          snap_nxt[op_r].tl = alu_diff[6:0];
        end
        op_nxt = op_r + 2'd1;
        if (op_r == fmvc_pkg::OP_LAST) begin
          iss_nxt   = '0;
          state_nxt = fmvc_pkg::ST_SEARCH;
        end
      end

      // Walk the table: issue one read and compare one entry per cycle
      fmvc_pkg::ST_SEARCH: begin
        if (cmp_vld_r && (tbl_rd_data == snap_voice)) begin
          res_index_nxt = 6'(cmp_idx_r);
          res_new_nxt   = 1'b0;
          res_full_nxt  = 1'b0;
          state_nxt     = fmvc_pkg::ST_RESULT;
        end else if (!cmp_vld_r && (iss_r >= count_r)) begin
          if (count_r >= COUNT_MAX) begin
            res_index_nxt = 6'd0;
            res_new_nxt   = 1'b0;
            res_full_nxt  = 1'b1;
          end else begin
            tbl_wr_en     = 1'b1;
            res_index_nxt = 6'(count_r);
            res_new_nxt   = 1'b1;
            res_full_nxt  = 1'b0;
            count_nxt     = count_r + CW'(1);
          end
          state_nxt = fmvc_pkg::ST_RESULT;
        end else if (iss_r < count_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r[IW-1:0];
          iss_nxt     = iss_r + CW'(1);
        end
      end

      // Hand the result to the output register once it is free
      fmvc_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_index_r;
          out_new_nxt   = res_new_r;
          out_full_nxt  = res_full_r;
          out_ch_nxt    = ch_r;
          state_nxt     = fmvc_pkg::ST_IDLE;
        end
      end

      default: state_nxt = fmvc_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmvc_pkg::ST_IDLE;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    op_r        <= op_nxt;
    min_r       <= min_nxt;
    ch_r        <= ch_nxt;
    connect_r   <= connect_nxt;
    snap_r      <= snap_nxt;
    rd_grp_r    <= rd_grp_nxt;
    rd_op_r     <= rd_op_nxt;
    iss_r       <= iss_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    res_index_r <= res_index_nxt;
    res_new_r   <= res_new_nxt;
    res_full_r  <= res_full_nxt;
    out_index_r <= out_index_nxt;
    out_new_r   <= out_new_nxt;
    out_full_r  <= out_full_nxt;
    out_ch_r    <= out_ch_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.voice_index = out_index_r;
  assign out_ch.is_new      = out_new_r;
  assign out_ch.table_full  = out_full_r;
  assign out_ch.key_channel = out_ch_r;

  // A full-table result never claims an append
  a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.is_new && out_ch.table_full))
    else $error("table_full result marked as new voice");

  // A full-table result is only given when the table is at capacity
  a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.table_full) |-> (count_r == COUNT_MAX))
    else $error("table_full reported below capacity");

  // The voice count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("voice count above table size");

  // A key-on with slot bits starts the register sweep
  a_keyon_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.reg_addr == fmvc_pkg::KEYON_ADDR) &&
     (in_ch.reg_data[6:3] != 4'd0)) |=> (state_r == fmvc_pkg::ST_GATHER))
    else $error("key-on did not start the register sweep");

endmodule
